>>> hdl/mfsm_pkg.sv
`timescale 1ns / 1ps

package mfsm_pkg;

  localparam logic [1:0] FAN_STOPPED      = 2'd0;
  localparam logic [1:0] FAN_RUNNING      = 2'd1;
  localparam logic [1:0] FAN_FAULT        = 2'd2;
  localparam logic [1:0] FAN_DISCONNECTED = 2'd3;

  localparam logic [1:0] MODE_FAULT = 2'd2;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_MANUAL_MODE    = 2'd1;
  localparam logic [1:0] CFG_POLL_DIVIDE    = 2'd2;
  localparam logic [1:0] CFG_MISS_LIMIT     = 2'd3;

  localparam logic [7:0]  READ_FUNCTION  = 8'h04;
  localparam logic [7:0]  MIN_STATUS_LEN = 8'd7;
  localparam logic [7:0]  MIN_FRAME_LEN  = 8'd4;
  localparam logic [7:0]  COUNT_MAX      = 8'hFF;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // Outcome of a closing byte, handed from frame assembly to the status logic.
  typedef struct packed {
    logic       accepted;
    logic       status_update;
    logic [1:0] fan1;
    logic [1:0] fan2;
  } frame_info_t;

  typedef struct packed {
    logic [1:0] fan1_state;
    logic [1:0] fan2_state;
    logic [1:0] mode_report;
    logic       any_running;
    logic       frame_accepted;
    logic       poll_due;
  } result_t;

  // Reflected CRC-16 update by one byte, one shift per bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  function automatic logic [1:0] decode_fan(input logic [7:0] v);
    logic [1:0] s;
    if (v == 8'd0) begin
      s = FAN_STOPPED;
    end else if (v == 8'd1) begin
      s = FAN_RUNNING;
    end else begin
      s = FAN_FAULT;
    end
    return s;
  endfunction

endpackage

>>> hdl/mfsm_frame.sv
`timescale 1ns / 1ps

module mfsm_frame import mfsm_pkg::*; #(
  parameter int RX_BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  input  logic [7:0]  device_address,
  output frame_info_t info
);

  localparam logic [8:0] BufLen = 9'(RX_BUFFER_BYTES);

  logic [15:0] running_crc;
  logic [15:0] crc_prev;
  logic [7:0]  last_byte;
  logic [7:0]  byte_count;
  logic [7:0]  field_addr;
  logic [7:0]  field_func;
  logic [7:0]  field_b4;
  logic [7:0]  field_b6;

  logic [7:0]  addr_eff;
  logic [7:0]  func_eff;
  logic [7:0]  b4_eff;
  logic [7:0]  b6_eff;
  logic [8:0]  frame_len;
  logic        len_ok;
  logic        crc_ok;
  logic        accepted;

  // The closing byte may itself land in a captured field position.
  always_comb begin
    addr_eff  = (byte_count == 8'd0) ? data_byte : field_addr;
    func_eff  = (byte_count == 8'd1) ? data_byte : field_func;
    b4_eff    = (byte_count == 8'd4) ? data_byte : field_b4;
    b6_eff    = (byte_count == 8'd6) ? data_byte : field_b6;
    frame_len = {1'b0, byte_count} + 9'd1;
    len_ok    = (byte_count != COUNT_MAX) && (frame_len >= {1'b0, MIN_FRAME_LEN})
                && (frame_len <= BufLen);
    crc_ok    = (crc_prev == {data_byte, last_byte});
    accepted  = en && frame_end && len_ok && crc_ok && (addr_eff == device_address);
    info.accepted      = accepted;
    info.status_update = accepted && (func_eff == READ_FUNCTION)
                         && (frame_len >= {1'b0, MIN_STATUS_LEN});
    info.fan1          = decode_fan(b4_eff);
    info.fan2          = decode_fan(b6_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CRC_INIT;
      crc_prev    <= CRC_INIT;
      last_byte   <= '0;
      byte_count  <= '0;
      field_addr  <= '0;
      field_func  <= '0;
      field_b4    <= '0;
      field_b6    <= '0;
    end else if (en) begin
      if (frame_end) begin
        running_crc <= CRC_INIT;
        crc_prev    <= CRC_INIT;
        last_byte   <= '0;
        byte_count  <= '0;
        field_addr  <= '0;
        field_func  <= '0;
        field_b4    <= '0;
        field_b6    <= '0;
      end else begin
        running_crc <= crc_byte(running_crc, data_byte);
        crc_prev    <= running_crc;
        last_byte   <= data_byte;
        if (byte_count != COUNT_MAX) begin
          byte_count <= byte_count + 8'd1;
        end
        field_addr <= addr_eff;
        field_func <= func_eff;
        field_b4   <= b4_eff;
        field_b6   <= b6_eff;
      end
    end
  end

endmodule

>>> hdl/mfsm_status.sv
`timescale 1ns / 1ps

module mfsm_status import mfsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_en,
  input  frame_info_t info,
  input  logic        manual_mode,
  input  logic [7:0]  poll_divide,
  input  logic [7:0]  miss_limit,
  output result_t     result
);

  logic [7:0] tick_count;
  logic [7:0] miss_count;
  logic [1:0] first_fan;
  logic [1:0] second_fan;

  logic [7:0] tick_next;
  logic [7:0] miss_next;
  logic [1:0] first_next;
  logic [1:0] second_next;
  logic [7:0] tick_inc;
  logic       poll;
  logic       fan_bad;

  always_comb begin
    tick_inc    = tick_count + 8'd1;
    tick_next   = tick_count;
    miss_next   = miss_count;
    first_next  = first_fan;
    second_next = second_fan;
    poll        = 1'b0;
    if (tick_en) begin
      tick_next = tick_inc;
      if (tick_inc == poll_divide) begin
        tick_next = '0;
        poll      = 1'b1;
        if (miss_count < miss_limit) begin
          miss_next = miss_count + 8'd1;
        end else begin
          first_next  = FAN_DISCONNECTED;
          second_next = FAN_DISCONNECTED;
        end
      end
    end else if (info.accepted) begin
      miss_next = '0;
      if (info.status_update) begin
        first_next  = info.fan1;
        second_next = info.fan2;
      end
    end
  end

  // Fault and disconnected both have the upper state bit set.
  always_comb begin
    fan_bad               = first_next[1] || second_next[1];
    result.fan1_state     = first_next;
    result.fan2_state     = second_next;
    result.mode_report    = fan_bad ? MODE_FAULT : {1'b0, manual_mode};
    result.any_running    = (first_next == FAN_RUNNING) || (second_next == FAN_RUNNING);
    result.frame_accepted = info.accepted;
    result.poll_due       = poll;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      miss_count <= '0;
      first_fan  <= FAN_STOPPED;
      second_fan <= FAN_STOPPED;
    end else begin
      tick_count <= tick_next;
      miss_count <= miss_next;
      first_fan  <= first_next;
      second_fan <= second_next;
    end
  end

endmodule

>>> hdl/modbus_fan_status_monitor.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// in       sink       in_valid / in_stall        action, data_byte, frame_end
// out      source     out_valid / out_stall      fan1_state, fan2_state, mode_report,
//                                                any_running, frame_accepted, poll_due
// cfg      sink       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low. A result passes from the input
// register through the frame check and status logic into the result register once
// its input transaction is accepted. The cfg port is always ready.
// Reset is synchronous and restores register defaults and an empty frame.
// A stalled result holds the pipeline; the input register keeps taking a new
// item whenever the result register is empty or being drained.

module modbus_fan_status_monitor import mfsm_pkg::*; #(
  parameter int RX_BUFFER_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] fan1_state,
  output logic [1:0] fan2_state,
  output logic [1:0] mode_report,
  output logic       any_running,
  output logic       frame_accepted,
  output logic       poll_due,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] device_address;
  logic       manual_mode;
  logic [7:0] poll_divide;
  logic [7:0] miss_limit;

  logic       stg_valid;
  logic       stg_action;
  logic [7:0] stg_byte;
  logic       stg_end;

  logic        advance;
  logic        proc;
  frame_info_t info;
  result_t     result;
  result_t     out_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd52;
      manual_mode    <= 1'b0;
      poll_divide    <= 8'd10;
      miss_limit     <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address <= cfg_data;
        CFG_MANUAL_MODE:    manual_mode    <= cfg_data[0];
        CFG_POLL_DIVIDE:    poll_divide    <= cfg_data;
        CFG_MISS_LIMIT:     miss_limit     <= cfg_data;
      endcase
    end
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = stg_valid && !advance;
  assign proc     = stg_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (!in_stall) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stg_action <= action;
      stg_byte   <= data_byte;
      stg_end    <= frame_end;
    end
  end

  mfsm_frame #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
  ) u_frame (
    .clk            (clk),
    .rst            (rst),
    .en             (proc && stg_action),
    .data_byte      (stg_byte),
    .frame_end      (stg_end),
    .device_address (device_address),
    .info           (info)
  );

  mfsm_status u_status (
    .clk         (clk),
    .rst         (rst),
    .tick_en     (proc && !stg_action),
    .info        (info),
    .manual_mode (manual_mode),
    .poll_divide (poll_divide),
    .miss_limit  (miss_limit),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_reg <= result;
    end
  end

  assign fan1_state     = out_reg.fan1_state;
  assign fan2_state     = out_reg.fan2_state;
  assign mode_report    = out_reg.mode_report;
  assign any_running    = out_reg.any_running;
  assign frame_accepted = out_reg.frame_accepted;
  assign poll_due       = out_reg.poll_due;

endmodule

>>> tb/fan_status_checker.sv
`timescale 1ns / 1ps

module fan_status_checker import mfsm_pkg::*; #(
  parameter int RX_BUFFER_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] fan1_state,
  input  logic [1:0] fan2_state,
  input  logic [1:0] mode_report,
  input  logic       any_running,
  input  logic       frame_accepted,
  input  logic       poll_due,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatch_count,
  output int         pending_results,
  output int         results_checked,
  output int         frames_accepted,
  output int         polls_started
);

  logic [7:0]  dev_addr;
  logic        manual_sel;
  logic [7:0]  poll_div;
  logic [7:0]  miss_lim;

  logic [7:0]  tick_cnt;
  logic [7:0]  miss_cnt;
  logic [1:0]  fan1;
  logic [1:0]  fan2;
  logic [15:0] crc_now;
  logic [15:0] crc_excl_last;
  logic [7:0]  prev_byte;
  logic [7:0]  bytes_seen;
  logic [7:0]  addr_fld;
  logic [7:0]  func_fld;
  logic [7:0]  status1_fld;
  logic [7:0]  status2_fld;

  result_t status_q[$];

  // Bit-serial form of the reflected CRC-16: data enters one bit at a time at the LSB.
  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic logic [1:0] fan_from_status(input logic [7:0] v);
    case (v)
      8'd0:    return FAN_STOPPED;
      8'd1:    return FAN_RUNNING;
      default: return FAN_FAULT;
    endcase
  endfunction

  function automatic void clear_frame();
    crc_now       = CRC_INIT;
    crc_excl_last = CRC_INIT;
    prev_byte     = 8'd0;
    bytes_seen    = 8'd0;
    addr_fld      = 8'd0;
    func_fld      = 8'd0;
    status1_fld   = 8'd0;
    status2_fld   = 8'd0;
  endfunction

  function automatic result_t next_status(input logic act, input logic [7:0] b,
                                          input logic fe);
    result_t    r;
    logic [7:0] pos;
    int         len;
    r = '0;
    if (!act) begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt == poll_div) begin
        tick_cnt  = 8'd0;
        r.poll_due = 1'b1;
        if (miss_cnt < miss_lim) begin
          miss_cnt = miss_cnt + 8'd1;
        end else begin
          fan1 = FAN_DISCONNECTED;
          fan2 = FAN_DISCONNECTED;
        end
      end
    end else begin
      pos = bytes_seen;
      case (pos)
        8'd0:    addr_fld    = b;
        8'd1:    func_fld    = b;
        8'd4:    status1_fld = b;
        8'd6:    status2_fld = b;
        default: ;
      endcase
      if (fe) begin
        len = int'(pos) + 1;
        // The CRC field is the closing byte (high) and the one before it (low).
        if (pos != COUNT_MAX && len >= int'(MIN_FRAME_LEN) && len <= RX_BUFFER_BYTES &&
            crc_excl_last == {b, prev_byte} && addr_fld == dev_addr) begin
          r.frame_accepted = 1'b1;
          miss_cnt = 8'd0;
          if (func_fld == READ_FUNCTION && len >= int'(MIN_STATUS_LEN)) begin
            fan1 = fan_from_status(status1_fld);
            fan2 = fan_from_status(status2_fld);
          end
        end
        clear_frame();
      end else begin
        crc_excl_last = crc_now;
        crc_now       = crc16_next(crc_now, b);
        prev_byte     = b;
        if (bytes_seen != COUNT_MAX) begin
          bytes_seen = bytes_seen + 8'd1;
        end
      end
    end
    r.fan1_state = fan1;
    r.fan2_state = fan2;
    if (fan1 == FAN_FAULT || fan2 == FAN_FAULT ||
        fan1 == FAN_DISCONNECTED || fan2 == FAN_DISCONNECTED) begin
      r.mode_report = MODE_FAULT;
    end else begin
      r.mode_report = {1'b0, manual_sel};
    end
    r.any_running = (fan1 == FAN_RUNNING) || (fan2 == FAN_RUNNING);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      dev_addr   = 8'd52;
      manual_sel = 1'b0;
      poll_div   = 8'd10;
      miss_lim   = 8'd5;
      tick_cnt   = 8'd0;
      miss_cnt   = 8'd0;
      fan1       = FAN_STOPPED;
      fan2       = FAN_STOPPED;
      clear_frame();
      status_q.delete();
      mismatch_count  <= 0;
      pending_results <= 0;
      results_checked <= 0;
      frames_accepted <= 0;
      polls_started   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEVICE_ADDRESS: dev_addr   = cfg_data;
          CFG_MANUAL_MODE:    manual_sel = cfg_data[0];
          CFG_POLL_DIVIDE:    poll_div   = cfg_data;
          CFG_MISS_LIMIT:     miss_lim   = cfg_data;
          default: ;
        endcase
      end

      // Results are compared before this edge's input is predicted; latency rules out
      // an input and its own result meeting at one edge.
      if (out_valid && !out_stall) begin
        seen = {fan1_state, fan2_state, mode_report, any_running, frame_accepted, poll_due};
        results_checked <= results_checked + 1;
        if (status_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("[%0t] result with no transaction outstanding: fan1=%0d fan2=%0d",
                     $time, seen.fan1_state, seen.fan2_state);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = status_q.pop_front();
          if (seen !== want) begin
            if (mismatch_count < 10) begin
              $display("[%0t] mismatch: expected fan1=%0d fan2=%0d mode=%0d run=%0b acc=%0b poll=%0b",
                       $time, want.fan1_state, want.fan2_state, want.mode_report,
                       want.any_running, want.frame_accepted, want.poll_due);
              $display("             got      fan1=%0d fan2=%0d mode=%0d run=%0b acc=%0b poll=%0b",
                       seen.fan1_state, seen.fan2_state, seen.mode_report,
                       seen.any_running, seen.frame_accepted, seen.poll_due);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end

      if (in_valid && !in_stall) begin
        want = next_status(action, data_byte, frame_end);
        status_q.push_back(want);
        if (want.frame_accepted) begin
          frames_accepted <= frames_accepted + 1;
        end
        if (want.poll_due) begin
          polls_started <= polls_started + 1;
        end
      end

      pending_results <= status_q.size();
    end
  end

endmodule

>>> tb/tb_modbus_fan_status_monitor.sv
`timescale 1ns / 1ps

module tb_modbus_fan_status_monitor;
  import mfsm_pkg::*;

  localparam int RX_BUF     = 64;
  localparam int IDLE_LIMIT = 2000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       action;
  logic [7:0] data_byte;
  logic       frame_end;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] fan1_state;
  logic [1:0] fan2_state;
  logic [1:0] mode_report;
  logic       any_running;
  logic       frame_accepted;
  logic       poll_due;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int mismatch_count;
  int pending_results;
  int results_checked;
  int frames_accepted;
  int polls_started;

  int         items_sent;
  int         cfg_writes;
  int         burst_left;
  int         quiet_cycles;
  int         stall_hold;
  int         stall_style;
  logic [7:0] stall_phase;
  logic [7:0] cur_addr;
  logic [7:0] frame_buf [0:299];

  modbus_fan_status_monitor #(.RX_BUFFER_BYTES(RX_BUF)) dut (.*);

  fan_status_checker #(.RX_BUFFER_BYTES(RX_BUF)) status_check (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: stretches of no stall, light and heavy random stall, and a periodic pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      stall_hold  <= 0;
      stall_style <= 0;
      stall_phase <= 8'd0;
    end else begin
      stall_phase <= stall_phase + 8'd1;
      if (stall_hold == 0) begin
        stall_style <= $urandom_range(0, 3);
        stall_hold  <= $urandom_range(40, 200);
      end else begin
        stall_hold <= stall_hold - 1;
      end
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_phase[2:0] < 3'd3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_results);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] b, input logic fe);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left = burst_left - 1;
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    frame_end <= fe;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Byte and end marker are don't-care on a tick, so they are randomized.
  task automatic send_tick();
    send_item(1'b0, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_tick();
      end
      send_item(1'b1, frame_buf[i], (i == len - 1));
    end
  endtask

  function automatic logic [7:0] pick_status();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return 8'd0;
    end else if (r < 8) begin
      return 8'd1;
    end
    return 8'($urandom_range(2, 255));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(7, 12);
    end else if (r < 85) begin
      return $urandom_range(4, 6);
    end
    return $urandom_range(13, 64);
  endfunction

  // Random payload with address, function and both status bytes in place, then a
  // CRC over everything but the last two bytes, low byte first.
  function automatic void fill_frame(input int len, input logic [7:0] addr,
                                     input logic [7:0] func);
    logic [15:0] crc;
    for (int i = 0; i < len; i++) begin
      frame_buf[i] = 8'($urandom);
    end
    frame_buf[0] = addr;
    if (len > 1) begin
      frame_buf[1] = func;
    end
    if (len > 4) begin
      frame_buf[4] = pick_status();
    end
    if (len > 6) begin
      frame_buf[6] = pick_status();
    end
    if (len >= 3) begin
      crc = CRC_INIT;
      for (int i = 0; i < len - 2; i++) begin
        crc = crc_byte(crc, frame_buf[i]);
      end
      frame_buf[len - 2] = crc[7:0];
      frame_buf[len - 1] = crc[15:8];
    end
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] addr, input logic man,
                              input logic [7:0] div, input logic [7:0] lim);
    logic [1:0] reg_idx [4];
    logic [7:0] reg_val [4];
    reg_idx = '{CFG_DEVICE_ADDRESS, CFG_MANUAL_MODE, CFG_POLL_DIVIDE, CFG_MISS_LIMIT};
    reg_val = '{addr, {7'd0, man}, div, lim};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_data  <= reg_val[i];
      do @(posedge clk); while (!cfg_ready);
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
    cur_addr = addr;
  endtask

  // Mostly well-formed frames to reach the status decode, plus ticks, corrupted
  // frames, foreign addresses, noise and short or oversize frames.
  task automatic one_burst(input int tick_pct);
    int r;
    int kind;
    int len;
    int n;
    int flip_at;
    r = $urandom_range(0, 99);
    if (r < tick_pct) begin
      n = $urandom_range(1, 8);
      repeat (n) send_tick();
    end else begin
      kind = $urandom_range(0, 99);
      len  = pick_len();
      if (kind < 80) begin
        fill_frame(len, cur_addr, ($urandom_range(0, 4) == 0) ? 8'($urandom) : READ_FUNCTION);
        if (kind >= 60 && kind < 72) begin
          flip_at = $urandom_range(0, len - 1);
          frame_buf[flip_at] = frame_buf[flip_at] ^ (8'd1 << $urandom_range(0, 7));
        end else if (kind >= 72) begin
          frame_buf[0] = cur_addr ^ 8'($urandom_range(1, 255));
        end
      end else if (kind < 90) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          frame_buf[i] = 8'($urandom);
        end
      end else if (kind < 97) begin
        len = $urandom_range(1, 3);
        fill_frame(len, cur_addr, READ_FUNCTION);
      end else begin
        len = $urandom_range(65, 70);
        fill_frame(len, cur_addr, READ_FUNCTION);
      end
      send_frame(len);
    end
  endtask

  task automatic run_phase(input logic [7:0] addr, input logic man, input logic [7:0] div,
                           input logic [7:0] lim, input int count, input int tick_pct);
    int stop_at;
    program_regs(addr, man, div, lim);
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      one_burst(tick_pct);
    end
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    action     <= 1'b0;
    data_byte  <= 8'd0;
    frame_end  <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_DEVICE_ADDRESS;
    cfg_data   <= 8'd0;
    items_sent = 0;
    cfg_writes = 0;
    burst_left = 0;
    cur_addr   = 8'd52;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: frame closed on its first byte, a short frame with a good CRC,
    // the shortest acceptable frame, and a status frame with running and fault.
    fill_frame(1, cur_addr, READ_FUNCTION);
    send_frame(1);
    fill_frame(3, cur_addr, READ_FUNCTION);
    send_frame(3);
    fill_frame(4, cur_addr, 8'h03);
    send_frame(4);
    fill_frame(9, cur_addr, READ_FUNCTION);
    frame_buf[4] = 8'd1;
    frame_buf[6] = 8'hFF;
    fill_frame_crc_fix: begin
      logic [15:0] crc;
      crc = CRC_INIT;
      for (int i = 0; i < 7; i++) begin
        crc = crc_byte(crc, frame_buf[i]);
      end
      frame_buf[7] = crc[7:0];
      frame_buf[8] = crc[15:8];
    end
    send_frame(9);
    send_item(1'b0, 8'hFF, 1'b1);
    send_item(1'b0, 8'h00, 1'b0);

    // A zero miss limit disconnects on every poll; a 7-byte status frame then takes
    // its second fan state from the high CRC byte.
    program_regs(8'hFF, 1'b1, 8'd1, 8'd0);
    send_tick();
    send_tick();
    fill_frame(7, cur_addr, READ_FUNCTION);
    send_frame(7);
    send_tick();

    run_phase(8'h5A, 1'b0, 8'd4, 8'd2, 100, 25);
    // Largest accepted frame, one byte too long, and one that saturates the count.
    fill_frame(RX_BUF, cur_addr, READ_FUNCTION);
    send_frame(RX_BUF);
    fill_frame(RX_BUF + 1, cur_addr, READ_FUNCTION);
    send_frame(RX_BUF + 1);
    fill_frame(257, cur_addr, READ_FUNCTION);
    send_frame(257);
    run_phase(8'h00, 1'b0, 8'd1, 8'd0, 80, 20);
    run_phase(8'hFF, 1'b1, 8'd255, 8'd255, 100, 30);
    // Lowered divide below the running tick count, then a zero divide.
    run_phase(8'($urandom_range(1, 254)), 1'b0, 8'd3, 8'd1, 280, 85);
    run_phase(8'($urandom_range(1, 254)), 1'b1, 8'd0, 8'd3, 280, 85);
    run_phase(8'($urandom_range(1, 254)), 1'b1, 8'd2, 8'd4, 80, 25);
    run_phase(8'd52, 1'b0, 8'd10, 8'd5, 60, 30);

    drain();
    repeat (8) @(posedge clk);
    $display("run covered %0d link transactions and %0d register writes over 8 settings",
             items_sent, cfg_writes);
    $display("%0d results checked, %0d frames accepted, %0d polls started",
             results_checked, frames_accepted, polls_started);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/mfsm_pkg.sv
hdl/mfsm_frame.sv
hdl/mfsm_status.sv
hdl/modbus_fan_status_monitor.sv
tb/fan_status_checker.sv
tb/tb_modbus_fan_status_monitor.sv
